@@ design/pvrt_pkg.sv @@
// Package with shared types, constants and helpers of the path vector route table.
package pvrt_pkg;

  localparam int NumRouters = 16;
  localparam int PathLen    = 8;
  localparam int IdxW       = $clog2(NumRouters);
  localparam int CntW       = $clog2(NumRouters + 1);
  localparam int QDepth     = 2;
  localparam logic [3:0] DirectLen = 4'd2;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_ADVERT = 3'd2,
    CMD_DEATH  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [0:0] {
    REG_MY_ID   = 1'b0,
    REG_COST_INF = 1'b1
  } reg_idx_t;

  // One classified command as it travels from the front to the back part.
  typedef struct packed {
    logic [2:0]  command;
    logic        in_range;
    logic [3:0]  router;
    logic [3:0]  sender;
    logic [16:0] sum;
    logic [15:0] route_cost;
    logic [3:0]  adv_len;
    logic [31:0] path;
    logic        adv_ok;
    logic        last_item;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0]  hop;
    logic [15:0] cost;
    logic [3:0]  len;
    logic [31:0] ids;
  } entry_t;

  typedef struct packed {
    logic        changed;
    logic        entry_valid;
    logic [3:0]  entry_next_hop;
    logic [15:0] entry_cost;
    logic [3:0]  entry_path_len;
    logic [31:0] entry_path;
    logic [4:0]  route_count;
  } result_t;

  // Mask that keeps the low n router ids of a path.
  function automatic logic [31:0] id_mask(input logic [4:0] n);
    logic [31:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (k < n) m[4*k +: 4] = 4'hF;
    end
    return m;
  endfunction

  // True when one of the first n ids of a path equals id.
  function automatic logic path_has(input logic [31:0] ids, input logic [3:0] n,
                                    input logic [3:0] id);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (k < n && ids[4*k +: 4] == id) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

@@ design/path_vector_route_table.sv @@
// Top level of the path vector route table.
//  channel | dir | handshake              | contents
//  s_axis  | in  | s_axis_tvalid/tready   | one command word
//  m_axis  | out | m_axis_tvalid/tready   | one result word per command
//  cfg     | in  | cfg_valid/cfg_ready    | register index and data
// Add, advertisement and read are applied in the back part, then presented.
// Init and neighbour death walk all 16 table entries in the back part.
// Reset empties the table and zeroes counters; my_id is 0, cost_infinity 999.
// A two-word queue lets commands be accepted while a result is stalled.
module path_vector_route_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], router[6:3], sender[10:7], link_cost[26:11],
  // route_cost[42:27], adv_len[46:43], path[78:47], zero pad
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // changed[0], entry_valid[1], entry_next_hop[5:2], entry_cost[21:6],
  // entry_path_len[25:22], entry_path[57:26], route_count[62:58], zero pad
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pvrt_pkg::*;

  logic [3:0]  my_id;
  logic [15:0] cost_infinity;
  logic        q_valid, q_take;
  cmd_word_t   q_word;
  result_t     res;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      my_id <= 4'd0;
      cost_infinity <= 16'd999;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MY_ID:    my_id <= cfg_data[3:0];
        REG_COST_INF: cost_infinity <= cfg_data;
        default: ;
      endcase
    end
  end

  pvrt_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .command(s_axis_tdata[2:0]), .router(s_axis_tdata[6:3]),
    .sender(s_axis_tdata[10:7]), .link_cost(s_axis_tdata[26:11]),
    .route_cost(s_axis_tdata[42:27]), .adv_len(s_axis_tdata[46:43]),
    .path(s_axis_tdata[78:47]), .last_item(s_axis_tlast),
    .my_id, .q_valid, .q_take, .q_word
  );

  pvrt_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_word, .my_id, .cost_infinity,
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
  );

  assign m_axis_tdata = {1'b0, res.route_count, res.entry_path, res.entry_path_len,
                         res.entry_cost, res.entry_next_hop, res.entry_valid,
                         res.changed};

endmodule

@@ design/pvrt_front.sv @@
// Front part: accepts commands, pre-checks advertisements and fills the queue.
module pvrt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          command,
  input  logic [3:0]          router,
  input  logic [3:0]          sender,
  input  logic [15:0]         link_cost,
  input  logic [15:0]         route_cost,
  input  logic [3:0]          adv_len,
  input  logic [31:0]         path,
  input  logic                last_item,
  input  logic [3:0]          my_id,
  output logic                q_valid,
  input  logic                q_take,
  output pvrt_pkg::cmd_word_t q_word
);
  import pvrt_pkg::*;

  cmd_word_t queue [QDepth];
  logic [0:0] wr_ptr, rd_ptr;
  logic [1:0] fill;
  cmd_word_t word;
  logic push;

  // Classify the incoming command.
  always_comb begin
    word.command    = command;
    word.in_range   = ({1'b0, router} < 5'(NumRouters));
    word.router     = router;
    word.sender     = sender;
    word.sum        = {1'b0, route_cost} + {1'b0, link_cost};
    word.route_cost = route_cost;
    word.adv_len    = adv_len;
    word.path       = path;
    word.adv_ok     = adv_len != 4'd0 && {1'b0, adv_len} <= 5'(PathLen - 1)
                      && !path_has(path, adv_len, my_id);
    word.last_item  = last_item;
  end

  assign in_ready = fill != 2'(QDepth);
  assign push     = in_valid && in_ready;
  assign q_valid  = fill != 2'd0;
  assign q_word   = queue[rd_ptr];

  // Two-entry queue toward the back part.
  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= word;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_take) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + 2'(push) - 2'(q_take);
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_take |-> fill != 2'd0) else $error("queue read while empty");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(QDepth)) else $error("queue overfilled");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    push && !q_take |=> fill == $past(fill) + 2'd1) else $error("fill count slip");

endmodule

@@ design/pvrt_back.sv @@
// Back part: applies commands to the table and builds one result word each.
module pvrt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_take,
  input  pvrt_pkg::cmd_word_t q_word,
  input  logic [3:0]          my_id,
  input  logic [15:0]         cost_infinity,
  output logic                res_valid,
  input  logic                res_ready,
  output pvrt_pkg::result_t   res
);
  import pvrt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_OUT  = 2'd2
  } bstate_t;

  bstate_t state, state_next;
  entry_t table_q [NumRouters];
  logic [CntW-1:0] valid_routes;
  logic packet_changed;
  logic [IdxW-1:0] walk;
  cmd_word_t cur;
  logic chg;

  entry_t e, ne;
  logic [IdxW-1:0] ri;
  logic [15:0] ncost;
  logic [3:0] nlen;
  logic accept, ch, last_walk;
  logic [4:0] ext_len;
  logic [31:0] adv_mask;

  assign ri = q_word.router[IdxW-1:0];
  assign e  = table_q[ri];
  assign last_walk = walk == IdxW'(NumRouters - 1);
  assign ext_len = {1'b0, q_word.adv_len} + 5'd1;

  // Advertisement decision for the entry at the head of the queue.
  always_comb begin
    ncost = (q_word.sum < {1'b0, cost_infinity}) ? q_word.sum[15:0] : cost_infinity;
    nlen = ext_len[3:0];
    accept = q_word.in_range && q_word.adv_ok &&
             (q_word.sender == e.hop || q_word.sum < {1'b0, e.cost} || e.len == 4'd0);
    ch = e.len == 4'd0 || e.hop != q_word.sender || e.cost != ncost || e.len != nlen;
    adv_mask = id_mask(5'(q_word.adv_len));
    ne.hop = q_word.sender;
    ne.cost = ncost;
    ne.len = nlen;
    ne.ids = (q_word.route_cost < cost_infinity)
           ? {q_word.path[27:0] & adv_mask[27:0], my_id}
           : e.ids;
    ne.ids = ne.ids & id_mask(ext_len);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (q_valid) begin
        if (q_word.command == CMD_INIT || q_word.command == CMD_DEATH)
          state_next = ST_WALK;
        else state_next = ST_OUT;
      end
      ST_WALK: if (last_walk) state_next = ST_OUT;
      ST_OUT:  if (res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_take    = state == ST_IDLE && q_valid;
    res_valid = state == ST_OUT;
  end

  assign res.changed        = chg;
  assign res.entry_valid    = cur.in_range && table_q[cur.router[IdxW-1:0]].len != 4'd0;
  assign res.entry_next_hop = cur.in_range ? table_q[cur.router[IdxW-1:0]].hop : '0;
  assign res.entry_cost     = cur.in_range ? table_q[cur.router[IdxW-1:0]].cost : '0;
  assign res.entry_path_len = cur.in_range ? table_q[cur.router[IdxW-1:0]].len : '0;
  assign res.entry_path     = cur.in_range ? table_q[cur.router[IdxW-1:0]].ids : '0;
  assign res.route_count    = 5'(valid_routes);

  // Table update, one entry per cycle during a walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid_routes <= '0;
      packet_changed <= 1'b0;
      walk <= '0;
      chg <= 1'b0;
      for (int i = 0; i < NumRouters; i++) table_q[i] <= '0;
    end else begin
      state <= state_next;
      if (q_take) begin
        cur <= q_word;
        walk <= '0;
        chg <= q_word.command == CMD_ADVERT && q_word.last_item &&
               (packet_changed || (accept && ch));
        case (q_word.command)
          CMD_INIT: begin
            packet_changed <= 1'b0;
            valid_routes <= '0;
          end
          CMD_ADD: if (q_word.in_range) begin
            if (e.len == 4'd0) valid_routes <= valid_routes + 1'b1;
            table_q[ri].hop  <= q_word.router;
            table_q[ri].cost <= q_word.route_cost;
            table_q[ri].len  <= DirectLen;
            table_q[ri].ids  <= {24'd0, q_word.router, my_id} & id_mask(5'(PathLen));
          end
          CMD_ADVERT: begin
            if (accept) begin
              if (e.len == 4'd0) valid_routes <= valid_routes + 1'b1;
              table_q[ri] <= ne;
            end
            if (q_word.last_item) packet_changed <= 1'b0;
            else if (accept && ch) packet_changed <= 1'b1;
          end
          default: ;
        endcase
      end
      if (state == ST_WALK) begin
        walk <= walk + 1'b1;
        if (cur.command == CMD_INIT) begin
          if ({1'b0, my_id} < 5'(NumRouters) && walk == my_id[IdxW-1:0]) begin
            table_q[walk] <= '{hop: my_id, cost: 16'd0, len: 4'd1, ids: {28'd0, my_id}};
            valid_routes <= CntW'(1);
          end else table_q[walk] <= '0;
        end else if (table_q[walk].len != 4'd0 &&
                     ({1'b0, walk} == {1'b0, cur.router} ||
                      path_has(table_q[walk].ids, table_q[walk].len, cur.router)))
          table_q[walk].cost <= cost_infinity;
      end
    end
  end

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |=> state != ST_IDLE) else $error("take without start");
  a_count: assert property (@(posedge clk) disable iff (rst)
    valid_routes <= CntW'(NumRouters)) else $error("route count overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res.route_count))
    else $error("result dropped");

endmodule
